// ===== hw/rtl/sqa_pkg.sv =====
// Shared types and constants for the single-query softmax attention block.
// No dependencies; every other file but sqa_ram refers to it by scoped names.
`default_nettype none

package sqa_pkg;

    // Default sizes.
    localparam int MAX_SEQ_DEF   = 256;
    localparam int MAX_DIM_DEF   = 64;
    localparam int EXP_DEPTH_DEF = 1024;

    // Field and arithmetic widths.
    localparam int SEQ_LEN_W  = 9;
    localparam int HEAD_DIM_W = 7;
    localparam int CFG_DATA_W = 9;
    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 16;
    localparam int SCORE_W    = 40;
    localparam int PROD_W     = 33;
    localparam int OUT_IDX_W  = 6;
    localparam int EXP_SHIFT  = 18;
    localparam int QUOT_W     = 17;
    localparam int DCNT_W     = 5;

    // exp(-1/64) in Q0.32; table starts at 1.0, held in Q32.32.
    localparam logic [63:0] EXP_RATIO_Q32 = 64'd4228380000;
    localparam logic [63:0] EXP_ONE_Q32   = 64'h0000_0001_0000_0000;

    // Action codes.
    localparam logic [1:0] ACT_LOAD_Q   = 2'd0;
    localparam logic [1:0] ACT_LOAD_KV  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE  = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;   // ignored

    // Configuration register indexes.
    typedef enum logic {
        CFG_SEQ_LEN  = 1'b0,
        CFG_HEAD_DIM = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         position;
        logic [5:0]         dim_index;
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
    } t_in;

    typedef struct packed {
        logic [5:0]         out_index;
        logic signed [15:0] out_value;
        logic               last;
    } t_out;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LDQ,
        OP_LDKV,
        OP_CLEAR,
        OP_SCORE,
        OP_WEIGHT,
        OP_ACC,
        OP_ZERO
    } t_op;

    typedef struct packed {
        t_op  op;
        logic first;   // first element of a reduction
        logic last;    // last element of a reduction
        logic olast;   // last output dimension
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic div_busy;
    } t_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCORE,
        ST_SDRAIN,
        ST_WEIGHT,
        ST_WDRAIN,
        ST_OUT,
        ST_OWAIT
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/sqa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sqa_ram #(
    parameter int W = 16,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sqa_ctrl.sv =====
// Controller: config registers, state machine and loop counters for load and compute.
// Depends on sqa_pkg.
`default_nettype none

module sqa_ctrl #(
    parameter int MAX_SEQ = sqa_pkg::MAX_SEQ_DEF,
    parameter int MAX_DIM = sqa_pkg::MAX_DIM_DEF,
    localparam int SAW = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1,
    localparam int QAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int KAW = (MAX_SEQ * MAX_DIM > 1) ? $clog2(MAX_SEQ * MAX_DIM) : 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [1:0]                      i_action,
    input  wire logic [7:0]                      i_position,
    input  wire logic [5:0]                      i_dim_index,
    input  wire logic                            i_cfg_we,
    input  wire sqa_pkg::t_cfg_idx               i_cfg_idx,
    input  wire logic [sqa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire sqa_pkg::t_stat                  i_stat,
    output logic                                 o_busy,
    output sqa_pkg::t_cmd                        o_cmd,
    output logic [SAW-1:0]                       o_p,
    output logic [QAW-1:0]                       o_d,
    output logic [KAW-1:0]                       o_addr
);

    localparam int PW = $clog2(MAX_SEQ + 1);
    localparam int DW = $clog2(MAX_DIM + 1);

    sqa_pkg::t_state r_state, n_state;
    logic [sqa_pkg::SEQ_LEN_W-1:0]  r_seq_len;
    logic [sqa_pkg::HEAD_DIM_W-1:0] r_head_dim;
    logic [PW-1:0]  r_p, n_p;
    logic [DW-1:0]  r_d, n_d;
    logic [KAW-1:0] r_base, n_base;

    logic [PW-1:0]  ns;
    logic [DW-1:0]  nd;
    logic           p_last, d_last, pos_ok, dim_ok;
    logic [KAW-1:0] ld_addr;

    // Effective lengths, clamped to the storage size
    assign ns = (32'(r_seq_len) > MAX_SEQ) ? PW'(MAX_SEQ) : PW'(r_seq_len);
    assign nd = (32'(r_head_dim) > MAX_DIM) ? DW'(MAX_DIM) : DW'(r_head_dim);
    assign p_last = (PW'(r_p + PW'(1)) == ns);
    assign d_last = (DW'(r_d + DW'(1)) == nd);

    // Load addressing
    assign pos_ok  = (32'(i_position) < MAX_SEQ);
    assign dim_ok  = (32'(i_dim_index) < MAX_DIM);
    assign ld_addr = KAW'(KAW'(i_position) * KAW'(MAX_DIM)) + KAW'(i_dim_index);

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len  <= sqa_pkg::SEQ_LEN_W'(256);
            r_head_dim <= sqa_pkg::HEAD_DIM_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sqa_pkg::CFG_SEQ_LEN:  r_seq_len  <= i_cfg_data;
                sqa_pkg::CFG_HEAD_DIM: r_head_dim <= i_cfg_data[sqa_pkg::HEAD_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqa_pkg::ST_IDLE;
            r_p     <= '0;
            r_d     <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_d     <= n_d;
            r_base  <= n_base;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_d     = r_d;
        n_base  = r_base;
        unique case (r_state)
            sqa_pkg::ST_IDLE: begin
                if (i_start && i_action == sqa_pkg::ACT_COMPUTE && nd != '0) begin
                    n_p     = '0;
                    n_d     = '0;
                    n_base  = '0;
                    n_state = (ns == '0) ? sqa_pkg::ST_OUT : sqa_pkg::ST_SCORE;
                end
            end
            sqa_pkg::ST_SCORE: begin
                if (d_last) begin
                    n_d    = '0;
                    n_p    = PW'(r_p + PW'(1));
                    n_base = KAW'(r_base + KAW'(MAX_DIM));
                    if (p_last) begin
                        n_state = sqa_pkg::ST_SDRAIN;
                    end
                end else begin
                    n_d = DW'(r_d + DW'(1));
                end
            end
            sqa_pkg::ST_SDRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_p     = '0;
                    n_state = sqa_pkg::ST_WEIGHT;
                end
            end
            sqa_pkg::ST_WEIGHT: begin
                n_p = PW'(r_p + PW'(1));
                if (p_last) begin
                    n_state = sqa_pkg::ST_WDRAIN;
                end
            end
            sqa_pkg::ST_WDRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_p     = '0;
                    n_d     = '0;
                    n_base  = '0;
                    n_state = sqa_pkg::ST_OUT;
                end
            end
            sqa_pkg::ST_OUT: begin
                if (ns == '0) begin
                    n_state = sqa_pkg::ST_OWAIT;
                end else begin
                    n_p    = PW'(r_p + PW'(1));
                    n_base = KAW'(r_base + KAW'(MAX_DIM));
                    if (p_last) begin
                        n_state = sqa_pkg::ST_OWAIT;
                    end
                end
            end
            sqa_pkg::ST_OWAIT: begin
                if (!i_stat.pipe_busy && !i_stat.div_busy) begin
                    if (d_last) begin
                        n_state = sqa_pkg::ST_IDLE;
                    end else begin
                        n_d     = DW'(r_d + DW'(1));
                        n_p     = '0;
                        n_base  = '0;
                        n_state = sqa_pkg::ST_OUT;
                    end
                end
            end
            default: n_state = sqa_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy       = (r_state != sqa_pkg::ST_IDLE);
        o_cmd.op     = sqa_pkg::OP_NONE;
        o_cmd.first  = 1'b0;
        o_cmd.last   = 1'b0;
        o_cmd.olast  = d_last;
        o_p          = r_p[SAW-1:0];
        o_d          = r_d[QAW-1:0];
        o_addr       = KAW'(r_base + KAW'(r_d));
        unique case (r_state)
            sqa_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        sqa_pkg::ACT_LOAD_Q: begin
                            if (dim_ok) begin
                                o_cmd.op = sqa_pkg::OP_LDQ;
                            end
                            o_d = i_dim_index[QAW-1:0];
                        end
                        sqa_pkg::ACT_LOAD_KV: begin
                            if (pos_ok && dim_ok) begin
                                o_cmd.op = sqa_pkg::OP_LDKV;
                            end
                            o_addr = ld_addr;
                        end
                        sqa_pkg::ACT_COMPUTE: begin
                            if (nd != '0) begin
                                o_cmd.op = sqa_pkg::OP_CLEAR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sqa_pkg::ST_SCORE: begin
                o_cmd.op    = sqa_pkg::OP_SCORE;
                o_cmd.first = (r_d == '0);
                o_cmd.last  = d_last;
            end
            sqa_pkg::ST_WEIGHT: begin
                o_cmd.op = sqa_pkg::OP_WEIGHT;
            end
            sqa_pkg::ST_OUT: begin
                if (ns == '0) begin
                    o_cmd.op = sqa_pkg::OP_ZERO;
                end else begin
                    o_cmd.op    = sqa_pkg::OP_ACC;
                    o_cmd.first = (r_p == '0);
                    o_cmd.last  = p_last;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sqa_dp.sv =====
// Datapath: query/key/value/score memories, multiply-accumulate pipeline,
// exp table, weight sum and the serial divider. Depends on sqa_pkg, sqa_ram.
`default_nettype none

module sqa_dp #(
    parameter int MAX_SEQ   = sqa_pkg::MAX_SEQ_DEF,
    parameter int MAX_DIM   = sqa_pkg::MAX_DIM_DEF,
    parameter int EXP_DEPTH = sqa_pkg::EXP_DEPTH_DEF,
    localparam int SAW = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1,
    localparam int QAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int KAW = (MAX_SEQ * MAX_DIM > 1) ? $clog2(MAX_SEQ * MAX_DIM) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sqa_pkg::t_cmd                i_cmd,
    input  wire logic [SAW-1:0]               i_p,
    input  wire logic [QAW-1:0]               i_d,
    input  wire logic [KAW-1:0]               i_addr,
    input  wire logic [sqa_pkg::SAMPLE_W-1:0] i_sample_a,
    input  wire logic [sqa_pkg::SAMPLE_W-1:0] i_sample_b,
    output sqa_pkg::t_stat                    o_stat,
    output logic                              o_valid,
    output sqa_pkg::t_out                     o_result
);

    localparam int TW   = (EXP_DEPTH > 1) ? $clog2(EXP_DEPTH) : 1;
    localparam int SW   = sqa_pkg::SCORE_W;
    localparam int ACW  = (SW > sqa_pkg::PROD_W + SAW) ? SW : sqa_pkg::PROD_W + SAW;
    localparam int WSW  = sqa_pkg::WEIGHT_W + SAW + 1;
    localparam int QW   = sqa_pkg::QUOT_W;
    localparam int DVW0 = (ACW > WSW + QW) ? ACW : WSW + QW;
    localparam int DVW  = DVW0 + 1;
    localparam int IXW  = SW - sqa_pkg::EXP_SHIFT;

    typedef logic [sqa_pkg::WEIGHT_W-1:0] t_tab [EXP_DEPTH];

    // exp(-i/64) in Q0.16, built by repeated multiply with half-up rounding
    function automatic t_tab f_build_tab();
        t_tab        tab;
        logic [63:0] acc;
        logic [63:0] e;
        acc = sqa_pkg::EXP_ONE_Q32;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            e      = (acc + 64'h8000) >> 16;
            tab[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
            acc    = (acc * sqa_pkg::EXP_RATIO_Q32 + 64'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam t_tab EXP_TAB = f_build_tab();

    // Memory read data
    logic signed [15:0] q_rd, k_rd, v_rd;
    logic        [SW-1:0] s_rd;
    logic        s_we;
    logic [SAW-1:0] s_waddr;
    logic [SW-1:0]  s_wdata;

    // Pipeline stages
    sqa_pkg::t_cmd r1_cmd, r2_cmd;
    logic [SAW-1:0] r1_p, r2_p, r3_p;
    logic [QAW-1:0] r1_d, r2_d;
    logic signed [sqa_pkg::PROD_W-1:0] r2_prod, n_prod;
    logic [TW-1:0]  r2_tidx;
    logic           r2_inr;
    logic           r3_v;
    logic [sqa_pkg::WEIGHT_W-1:0] r3_w;

    logic signed [ACW-1:0] r_acc, sum;
    logic signed [SW-1:0]  r_max, diff;
    logic [IXW-1:0]        idx;
    logic [WSW-1:0]        r_wsum;

    // Divider
    logic              r_dbusy;
    logic [sqa_pkg::DCNT_W-1:0] r_dcnt;
    logic [DVW-1:0]    r_rem, r_den;
    logic [QW-1:0]     r_q;
    logic              r_dneg, r_dzero, r_dlast;
    logic [QAW-1:0]    r_didx;
    logic              div_go, go_zero, sum_neg;
    logic [ACW-1:0]    sum_mag;

    logic in_pipe;
    assign in_pipe = (i_cmd.op == sqa_pkg::OP_SCORE) || (i_cmd.op == sqa_pkg::OP_WEIGHT)
                  || (i_cmd.op == sqa_pkg::OP_ACC);

    sqa_ram #(.W(sqa_pkg::SAMPLE_W), .D(MAX_DIM)) u_qram (
        .i_clk(i_clk), .i_we(i_cmd.op == sqa_pkg::OP_LDQ), .i_waddr(i_d),
        .i_wdata(i_sample_a), .i_raddr(i_d), .o_rdata(q_rd)
    );

    sqa_ram #(.W(sqa_pkg::SAMPLE_W), .D(MAX_SEQ * MAX_DIM)) u_kram (
        .i_clk(i_clk), .i_we(i_cmd.op == sqa_pkg::OP_LDKV), .i_waddr(i_addr),
        .i_wdata(i_sample_a), .i_raddr(i_addr), .o_rdata(k_rd)
    );

    sqa_ram #(.W(sqa_pkg::SAMPLE_W), .D(MAX_SEQ * MAX_DIM)) u_vram (
        .i_clk(i_clk), .i_we(i_cmd.op == sqa_pkg::OP_LDKV), .i_waddr(i_addr),
        .i_wdata(i_sample_b), .i_raddr(i_addr), .o_rdata(v_rd)
    );

    // Scores, later overwritten in place by weights
    sqa_ram #(.W(SW), .D(MAX_SEQ)) u_sram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr),
        .i_wdata(s_wdata), .i_raddr(i_p), .o_rdata(s_rd)
    );

    // Stage 1: memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_cmd <= '{op: sqa_pkg::OP_NONE, default: 1'b0};
        end else begin
            r1_cmd <= in_pipe ? i_cmd : '{op: sqa_pkg::OP_NONE, default: 1'b0};
        end
        r1_p <= i_p;
        r1_d <= i_d;
    end

    // Stage 2: multiply, or score-to-table-index
    always_comb begin
        if (r1_cmd.op == sqa_pkg::OP_ACC) begin
            n_prod = sqa_pkg::PROD_W'($signed({1'b0, s_rd[sqa_pkg::WEIGHT_W-1:0]}) * v_rd);
        end else begin
            n_prod = sqa_pkg::PROD_W'(q_rd * k_rd);
        end
    end
    assign diff = r_max - $signed(s_rd);
    assign idx  = diff[SW-1:sqa_pkg::EXP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_cmd <= '{op: sqa_pkg::OP_NONE, default: 1'b0};
        end else begin
            r2_cmd <= r1_cmd;
        end
        r2_p    <= r1_p;
        r2_d    <= r1_d;
        r2_prod <= n_prod;
        r2_tidx <= idx[TW-1:0];
        r2_inr  <= (32'(idx) < EXP_DEPTH);
    end

    // Stage 3: accumulate; table lookup for weights
    assign sum = (r2_cmd.first ? ACW'(0) : r_acc) + ACW'(r2_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= (r2_cmd.op == sqa_pkg::OP_WEIGHT);
        end
        r3_p <= r2_p;
        r3_w <= r2_inr ? EXP_TAB[r2_tidx] : '0;
        if (r2_cmd.op == sqa_pkg::OP_SCORE || r2_cmd.op == sqa_pkg::OP_ACC) begin
            r_acc <= sum;
        end
        if (r2_cmd.op == sqa_pkg::OP_SCORE && r2_cmd.last) begin
            if (r2_p == '0 || $signed(sum[SW-1:0]) > r_max) begin
                r_max <= sum[SW-1:0];
            end
        end
        // Weight sum
        if (i_cmd.op == sqa_pkg::OP_CLEAR) begin
            r_wsum <= '0;
        end else if (r3_v) begin
            r_wsum <= WSW'(r_wsum + WSW'(r3_w));
        end
    end

    // Score RAM write: score at end of a dot product, weight at stage 3
    always_comb begin
        s_we    = r3_v || (r2_cmd.op == sqa_pkg::OP_SCORE && r2_cmd.last);
        s_waddr = r3_v ? r3_p : r2_p;
        s_wdata = r3_v ? SW'(r3_w) : sum[SW-1:0];
    end

    // Divider launch
    assign go_zero = (i_cmd.op == sqa_pkg::OP_ZERO);
    assign div_go  = go_zero || (r2_cmd.op == sqa_pkg::OP_ACC && r2_cmd.last);
    assign sum_neg = sum[ACW-1];
    assign sum_mag = sum_neg ? ACW'(-sum) : ACW'(sum);

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (div_go) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == '0) begin
                r_dbusy <= 1'b0;
                o_valid <= 1'b1;
            end
        end
        if (div_go) begin
            r_dcnt  <= sqa_pkg::DCNT_W'(QW);
            r_rem   <= go_zero ? DVW'(0) : DVW'(DVW'(sum_mag) + DVW'(r_wsum >> 1));
            r_den   <= DVW'(r_wsum) << (QW - 1);
            r_q     <= '0;
            r_dneg  <= go_zero ? 1'b0 : sum_neg;
            r_dzero <= go_zero || (r_wsum == '0);
            r_didx  <= go_zero ? i_d : r2_d;
            r_dlast <= go_zero ? i_cmd.olast : r2_cmd.olast;
        end else if (r_dbusy && r_dcnt != '0) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
            r_den  <= r_den >> 1;
            r_dcnt <= sqa_pkg::DCNT_W'(r_dcnt - 1'b1);
        end
        // Rounded, saturated result
        if (r_dbusy && r_dcnt == '0 && !div_go) begin
            o_result.out_index <= sqa_pkg::OUT_IDX_W'(r_didx);
            o_result.last      <= r_dlast;
            if (r_dzero) begin
                o_result.out_value <= '0;
            end else if (r_dneg) begin
                o_result.out_value <= (r_q > QW'(32768)) ? 16'sh8000 : 16'(-r_q);
            end else begin
                o_result.out_value <= (r_q > QW'(32767)) ? 16'sh7FFF : r_q[15:0];
            end
        end
    end

    assign o_stat.pipe_busy = (r1_cmd.op != sqa_pkg::OP_NONE)
                           || (r2_cmd.op != sqa_pkg::OP_NONE) || r3_v;
    assign o_stat.div_busy  = r_dbusy;

endmodule

`default_nettype wire

// ===== hw/rtl/single_query_softmax_attention.sv =====
// Top level of the single-query softmax attention block.
// Depends on sqa_pkg, sqa_ctrl, sqa_dp (and sqa_ram below it).
//
//  channel  | ports                               | transfer
//  ---------+-------------------------------------+------------------------------
//  input    | i_start, o_busy, i_item             | edge with i_start & !o_busy
//  result   | o_strobe, o_result                  | every cycle o_strobe is high
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data     | edge with i_cfg_we high
//
// Load items leave busy low. A compute item does one MAC per cycle through the
// key and value memories, plus a serial divide per output dimension. Reset is
// synchronous, active low, and needs no clearing pass. Results are strobed for
// one cycle; the receiver cannot stall.
`default_nettype none

module single_query_softmax_attention #(
    parameter int MAX_SEQ   = sqa_pkg::MAX_SEQ_DEF,
    parameter int MAX_DIM   = sqa_pkg::MAX_DIM_DEF,
    parameter int EXP_DEPTH = sqa_pkg::EXP_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire sqa_pkg::t_in                    i_item,
    output logic                                 o_strobe,
    output sqa_pkg::t_out                        o_result,
    input  wire logic                            i_cfg_we,
    input  wire sqa_pkg::t_cfg_idx               i_cfg_idx,
    input  wire logic [sqa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SAW = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
    localparam int QAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int KAW = (MAX_SEQ * MAX_DIM > 1) ? $clog2(MAX_SEQ * MAX_DIM) : 1;

    sqa_pkg::t_cmd  cmd;
    sqa_pkg::t_stat stat;
    logic [SAW-1:0] cmd_p;
    logic [QAW-1:0] cmd_d;
    logic [KAW-1:0] cmd_addr;

    sqa_ctrl #(.MAX_SEQ(MAX_SEQ), .MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_action    (i_item.action),
        .i_position  (i_item.position),
        .i_dim_index (i_item.dim_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_busy      (o_busy),
        .o_cmd       (cmd),
        .o_p         (cmd_p),
        .o_d         (cmd_d),
        .o_addr      (cmd_addr)
    );

    sqa_dp #(.MAX_SEQ(MAX_SEQ), .MAX_DIM(MAX_DIM), .EXP_DEPTH(EXP_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_p        (cmd_p),
        .i_d        (cmd_d),
        .i_addr     (cmd_addr),
        .i_sample_a (i_item.sample_a),
        .i_sample_b (i_item.sample_b),
        .o_stat     (stat),
        .o_valid    (o_strobe),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sqa_check.sv =====
// Port-level checker for the attention block, bound to the top level.
// Depends on sqa_pkg.
`default_nettype none

module sqa_check (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_start,
    input wire logic                            o_busy,
    input wire sqa_pkg::t_in                    i_item,
    input wire logic                            o_strobe,
    input wire sqa_pkg::t_out                   o_result,
    input wire logic                            i_cfg_we
);

    // Results come only out of a running compute
    a_strobe_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(o_busy))
        else $error("result transfer outside a compute");

    // Load and ignored items leave the block idle
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.action != sqa_pkg::ACT_COMPUTE) |=> !o_busy)
        else $error("busy after a load transfer");

    // Serial divide spaces results apart
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result transfers");

    // Compute ends right after its final result
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> !o_busy)
        else $error("still busy after final result");

    // Registers are to be written only while idle; the block does not enforce it
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_busy)
        else $error("config write during a compute");

endmodule

bind single_query_softmax_attention sqa_check u_sqa_check (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for single_query_softmax_attention.
// Depends on sqa_pkg and the RTL of the block; holds its own score/softmax predictor.
`default_nettype none

module tb;

    localparam int NSEQ      = 256;
    localparam int NDIM      = 64;
    localparam int EXP_DEPTH = 1024;
    localparam int IDLE_LIMIT = 200000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_start = 1'b0;
    logic                           o_busy;
    sqa_pkg::t_in                   i_item = '0;
    logic                           o_strobe;
    sqa_pkg::t_out                  o_result;
    logic                           i_cfg_we = 1'b0;
    sqa_pkg::t_cfg_idx              i_cfg_idx = sqa_pkg::CFG_SEQ_LEN;
    logic [sqa_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    single_query_softmax_attention uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state
    logic [15:0]   exp_lut [EXP_DEPTH];
    shortint       q_vec [NDIM];
    shortint       k_mem [NSEQ*NDIM];
    shortint       v_mem [NSEQ*NDIM];
    bit            q_seen [NDIM];
    bit            kv_seen [NSEQ*NDIM];
    int unsigned   seq_len_r;
    int unsigned   head_dim_r;
    sqa_pkg::t_out attn_expected [$];

    int errors = 0;
    int items_sent = 0;
    int computes_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    function automatic void build_exp_lut();
        logic [127:0] acc;
        logic [127:0] e;
        acc = 128'(1) << 32;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            e = (acc + 128'h8000) >> 16;
            exp_lut[i] = (e > 128'd65535) ? 16'hFFFF : e[15:0];
            acc = (acc * 128'd4228380000 + 128'h8000_0000) >> 32;
        end
    endfunction

    function automatic int unsigned eff_seq();
        return (seq_len_r > NSEQ) ? NSEQ : seq_len_r;
    endfunction

    function automatic int unsigned eff_dim();
        return (head_dim_r > NDIM) ? NDIM : head_dim_r;
    endfunction

    // Expected outputs of one compute: softmax-weighted value rows
    function automatic void predict_attention();
        int unsigned ns, nd;
        longint sc [NSEQ];
        longint mx, wsum, acc, mag, r, qv, diff, idx;
        sqa_pkg::t_out res;
        ns = eff_seq();
        nd = eff_dim();
        mx = 0;
        wsum = 0;
        if (nd == 0) return;
        for (int p = 0; p < ns; p++) begin
            sc[p] = 0;
            for (int d = 0; d < nd; d++)
                sc[p] += longint'(q_vec[d]) * longint'(k_mem[p*NDIM+d]);
            if (p == 0 || sc[p] > mx) mx = sc[p];
        end
        for (int p = 0; p < ns; p++) begin
            diff = mx - sc[p];
            idx = diff >>> 18;
            sc[p] = (idx < EXP_DEPTH) ? longint'(exp_lut[idx]) : 0;
            wsum += sc[p];
        end
        for (int d = 0; d < nd; d++) begin
            acc = 0;
            qv = 0;
            for (int p = 0; p < ns; p++)
                acc += sc[p] * longint'(v_mem[p*NDIM+d]);
            if (wsum > 0) begin
                mag = (acc < 0) ? -acc : acc;
                r = (mag + wsum / 2) / wsum;
                if (acc < 0) qv = (r > 32768) ? -32768 : -r;
                else         qv = (r > 32767) ? 32767 : r;
            end
            res.out_index = d[5:0];
            res.out_value = qv[15:0];
            res.last      = (d + 1 == nd);
            attn_expected.push_back(res);
        end
    endfunction

    function automatic void apply_item(sqa_pkg::t_in it);
        case (it.action)
            sqa_pkg::ACT_LOAD_Q: begin
                q_vec[it.dim_index]  = it.sample_a;
                q_seen[it.dim_index] = 1'b1;
            end
            sqa_pkg::ACT_LOAD_KV: begin
                k_mem[{it.position, it.dim_index}]   = it.sample_a;
                v_mem[{it.position, it.dim_index}]   = it.sample_b;
                kv_seen[{it.position, it.dim_index}] = 1'b1;
            end
            sqa_pkg::ACT_COMPUTE: predict_attention();
            default: ;
        endcase
    endfunction

    // One input transfer; start stays high until the next gap lowers it
    task automatic send_item(sqa_pkg::t_in it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on && $urandom_range(0, 2) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        apply_item(it);
        items_sent++;
        if (it.action == sqa_pkg::ACT_COMPUTE) computes_sent++;
    endtask

    function automatic sqa_pkg::t_in mk_item(logic [1:0] act, int pos, int dim, int a, int b);
        sqa_pkg::t_in it;
        it.action    = act;
        it.position  = pos[7:0];
        it.dim_index = dim[5:0];
        it.sample_a  = a[15:0];
        it.sample_b  = b[15:0];
        return it;
    endfunction

    function automatic int rnd16();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 255) - 128;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    // Wait until the block is drained, then write one register
    task automatic cfg_write(sqa_pkg::t_cfg_idx idx, int data);
        i_start <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (attn_expected.size() != 0 || o_busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[sqa_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sqa_pkg::CFG_SEQ_LEN) seq_len_r = data & 'h1FF;
        else                             head_dim_r = data & 'h7F;
    endtask

    task automatic set_shape(int ns, int nd);
        cfg_write(sqa_pkg::CFG_SEQ_LEN, ns);
        cfg_write(sqa_pkg::CFG_HEAD_DIM, nd);
    endtask

    // Load every entry the next compute will read that is not yet written
    task automatic fill_missing();
        for (int d = 0; d < eff_dim(); d++)
            if (!q_seen[d])
                send_item(mk_item(sqa_pkg::ACT_LOAD_Q, $urandom_range(0, 255), d,
                                  rnd16(), 0));
        for (int p = 0; p < eff_seq(); p++)
            for (int d = 0; d < eff_dim(); d++)
                if (!kv_seen[p*NDIM+d])
                    send_item(mk_item(sqa_pkg::ACT_LOAD_KV, p, d, rnd16(), rnd16()));
    endtask

    task automatic compute_now();
        fill_missing();
        send_item(mk_item(sqa_pkg::ACT_COMPUTE, $urandom_range(0, 255),
                          $urandom_range(0, 63), rnd16(), rnd16()));
    endtask

    // Field extremes and every action
    task automatic test_field_extremes();
        set_shape(2, 2);
        send_item(mk_item(sqa_pkg::ACT_LOAD_Q, 0, 0, 32767, 0));
        send_item(mk_item(sqa_pkg::ACT_LOAD_Q, 0, 1, -32768, 0));
        send_item(mk_item(sqa_pkg::ACT_LOAD_KV, 0, 0, 32767, 32767));
        send_item(mk_item(sqa_pkg::ACT_LOAD_KV, 0, 1, -32768, 32767));
        send_item(mk_item(sqa_pkg::ACT_LOAD_KV, 1, 0, -32768, -32768));
        send_item(mk_item(sqa_pkg::ACT_LOAD_KV, 1, 1, 32767, -32768));
        compute_now();
        // far entries loaded but unused; unused action ignored
        send_item(mk_item(sqa_pkg::ACT_LOAD_KV, 255, 63, -1, -1));
        send_item(mk_item(sqa_pkg::ACT_RESERVED, 255, 63, -1, -1));
        send_item(mk_item(sqa_pkg::ACT_LOAD_KV, 1, 0, 0, 5));
        compute_now();
    endtask

    // Zero sizes and a head size past the array limit
    task automatic test_special_sizes();
        set_shape(3, 0);
        compute_now();
        set_shape(0, 3);
        compute_now();
        set_shape(1, 127);
        compute_now();
    endtask

    // Random shapes, well-formed load/compute sequences mixed with noise
    task automatic test_random_traffic();
        int n, pos, dim;
        while (items_sent < 260) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            set_shape($urandom_range(1, 6), $urandom_range(1, 6));
            repeat ($urandom_range(1, 3)) begin
                n = $urandom_range(2, 10);
                repeat (n) begin
                    pos = $urandom_range(0, eff_seq() - 1);
                    dim = $urandom_range(0, eff_dim() - 1);
                    case ($urandom_range(0, 7))
                        0: send_item(mk_item(sqa_pkg::ACT_LOAD_Q, $urandom_range(0, 255),
                                             dim, rnd16(), rnd16()));
                        1: send_item(mk_item(sqa_pkg::ACT_RESERVED, $urandom_range(0, 255),
                                             $urandom_range(0, 63), rnd16(), rnd16()));
                        2: send_item(mk_item(sqa_pkg::ACT_LOAD_KV, $urandom_range(0, 255),
                                             $urandom_range(0, 63), rnd16(), rnd16()));
                        default: send_item(mk_item(sqa_pkg::ACT_LOAD_KV, pos, dim,
                                                   rnd16(), rnd16()));
                    endcase
                end
                compute_now();
            end
        end
    endtask

    // Result checking against the oldest expectation
    always @(posedge i_clk) begin
        sqa_pkg::t_out exp_r;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (attn_expected.size() == 0) begin
                $display("%0t: unexpected result idx=%0d val=%0d last=%0b", $time,
                         o_result.out_index, o_result.out_value, o_result.last);
                errors++;
            end else begin
                exp_r = attn_expected.pop_front();
                if (o_result.out_index !== exp_r.out_index) begin
                    $display("%0t: out_index expected %0d actual %0d", $time,
                             exp_r.out_index, o_result.out_index);
                    errors++;
                end
                if (o_result.out_value !== exp_r.out_value) begin
                    $display("%0t: out_value expected %0d actual %0d (index %0d)", $time,
                             exp_r.out_value, o_result.out_value, exp_r.out_index);
                    errors++;
                end
                if (o_result.last !== exp_r.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             exp_r.last, o_result.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[single_query_softmax_attention] ERROR");
            $finish;
        end
    end

    initial begin
        build_exp_lut();
        seq_len_r  = 256;
        head_dim_r = 64;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_special_sizes();
        test_random_traffic();
        i_start <= 1'b0;
        while (attn_expected.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items (%0d computes), checked %0d results, %0d mismatches.",
                 items_sent, computes_sent, results_seen, errors);
        if (errors == 0) $display("[single_query_softmax_attention] OK");
        else             $display("[single_query_softmax_attention] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
